[rtl/core/hdde_pkg.sv]
// Shared types and constants for the hash dictionary dedup encoder.
// No dependencies; hdde_ctrl, hdde_dpath and the top level import this package.
`timescale 1ns / 1ps

package hdde_pkg;

    // Multiplicative hash constant; the home slot is the low bits of key times this
    localparam logic [63:0] HASH_MULT  = 64'h9e3779b97f4a7c15;
    localparam logic [15:0] EMPTY_CODE = 16'hFFFF;
    localparam logic [15:0] SAT_CODE   = 16'hFFFE;

    // Operation codes carried in s_tuser
    localparam logic [2:0] FUNC_CLEAR   = 3'd0;
    localparam logic [2:0] FUNC_INSERT  = 3'd1;
    localparam logic [2:0] FUNC_LOOKUP  = 3'd2;
    localparam logic [2:0] FUNC_WRCODE  = 3'd3;
    localparam logic [2:0] FUNC_EXTRACT = 3'd4;

    // Result status codes carried in m_tuser
    localparam logic [2:0] STAT_DONE     = 3'd0;
    localparam logic [2:0] STAT_NEW      = 3'd1;
    localparam logic [2:0] STAT_PRESENT  = 3'd2;
    localparam logic [2:0] STAT_NOTFOUND = 3'd3;
    localparam logic [2:0] STAT_LIMIT    = 3'd4;
    localparam logic [2:0] STAT_END      = 3'd5;

    // Table address source
    localparam logic [1:0] ADDR_PROBE  = 2'd0;
    localparam logic [1:0] ADDR_SLOT   = 2'd1;
    localparam logic [1:0] ADDR_CURSOR = 2'd2;
    localparam logic [1:0] ADDR_CLEAR  = 2'd3;

    // Code write data source
    localparam logic [1:0] CW_EMPTY = 2'd0;
    localparam logic [1:0] CW_ZERO  = 2'd1;
    localparam logic [1:0] CW_CODE  = 2'd2;

    // Result word kinds
    localparam logic [3:0] RES_DONE     = 4'd0;
    localparam logic [3:0] RES_NEW      = 4'd1;
    localparam logic [3:0] RES_PRESENT  = 4'd2;
    localparam logic [3:0] RES_NOTFOUND = 4'd3;
    localparam logic [3:0] RES_LIMIT    = 4'd4;
    localparam logic [3:0] RES_FOUND    = 4'd5;
    localparam logic [3:0] RES_WR_EMPTY = 4'd6;
    localparam logic [3:0] RES_WR_OK    = 4'd7;
    localparam logic [3:0] RES_EXT      = 4'd8;
    localparam logic [3:0] RES_END      = 4'd9;

    // Controller to datapath commands
    typedef struct packed {
        logic       in_ready;
        logic       hash;
        logic       step;
        logic [1:0] addr_sel;
        logic       key_we;
        logic       code_we;
        logic [1:0] code_wsel;
        logic       clr_step;
        logic       clr_done;
        logic       uniq_inc;
        logic       cursor_inc;
        logic       res_load;
        logic [3:0] res_sel;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] func;
        logic       code_empty;
        logic       key_match;
        logic       probe_limit;
        logic       cursor_end;
        logic       clr_last;
        logic       out_busy;
    } sts_t;

endpackage

[rtl/core/hdde_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hdde_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write when enabled, read every cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/core/hdde_ctrl.sv]
// Sequencer for the dictionary: clearing sweep, hash, probe loop, slot write, extract.
// Depends on hdde_pkg.
`timescale 1ns / 1ps

module hdde_ctrl
    import hdde_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  sts_t sts,
    input  logic accepted,
    output cmd_t cmd
);

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_CLR_END = 3'd1;
    localparam logic [2:0] S_IDLE    = 3'd2;
    localparam logic [2:0] S_HASH    = 3'd3;
    localparam logic [2:0] S_READ    = 3'd4;
    localparam logic [2:0] S_CHECK   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       report_reg, report_next;
    logic [1:0] func_addr;

    // Pick the table address from the operation
    always_comb begin
        case (sts.func)
            FUNC_WRCODE:  func_addr = ADDR_SLOT;
            FUNC_EXTRACT: func_addr = ADDR_CURSOR;
            default:      func_addr = ADDR_PROBE;
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        report_next = report_reg;
        cmd         = '0;
        cmd.addr_sel = func_addr;
        cmd.code_wsel = CW_EMPTY;
        cmd.res_sel  = RES_DONE;
        case (state_reg)
            // Sweep every code to empty
            S_CLEAR: begin
                cmd.addr_sel = ADDR_CLEAR;
                cmd.code_we  = 1'b1;
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_CLR_END;
                end
            end
            S_CLR_END: begin
                if (!report_reg) begin
                    cmd.clr_done = 1'b1;
                    state_next   = S_IDLE;
                end else if (!sts.out_busy) begin
                    cmd.clr_done = 1'b1;
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_DONE;
                    report_next  = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            // Accept moves idle to hash; the datapath latches the word
            S_IDLE: begin
                cmd.in_ready = 1'b1;
                if (accepted) begin
                    state_next = S_HASH;
                end
            end
            // Home slot is registered; dispatch on the operation
            S_HASH: begin
                cmd.hash = 1'b1;
                case (sts.func)
                    FUNC_CLEAR: begin
                        report_next = 1'b1;
                        state_next  = S_CLEAR;
                    end
                    FUNC_INSERT, FUNC_LOOKUP, FUNC_WRCODE, FUNC_EXTRACT: begin
                        state_next = S_READ;
                    end
                    default: state_next = S_CHECK;
                endcase
            end
            S_READ: begin
                state_next = S_CHECK;
            end
            // Evaluate the slot just read; hold while the result register is full
            S_CHECK: begin
                if (!sts.out_busy) begin
                    state_next  = S_IDLE;
                    cmd.res_load = 1'b1;
                    case (sts.func)
                        FUNC_INSERT, FUNC_LOOKUP: begin
                            if (sts.code_empty) begin
                                if (sts.func == FUNC_INSERT) begin
                                    cmd.key_we    = 1'b1;
                                    cmd.code_we   = 1'b1;
                                    cmd.code_wsel = CW_ZERO;
                                    cmd.uniq_inc  = 1'b1;
                                    cmd.res_sel   = RES_NEW;
                                end else begin
                                    cmd.res_sel = RES_NOTFOUND;
                                end
                            end else if (sts.key_match) begin
                                cmd.res_sel = (sts.func == FUNC_INSERT) ? RES_PRESENT
                                                                        : RES_FOUND;
                            end else if (sts.probe_limit) begin
                                cmd.res_sel = RES_LIMIT;
                            end else begin
                                cmd.res_load = 1'b0;
                                cmd.step     = 1'b1;
                                state_next   = S_READ;
                            end
                        end
                        FUNC_WRCODE: begin
                            if (sts.code_empty) begin
                                cmd.res_sel = RES_WR_EMPTY;
                            end else begin
                                cmd.code_we   = 1'b1;
                                cmd.code_wsel = CW_CODE;
                                cmd.res_sel   = RES_WR_OK;
                            end
                        end
                        FUNC_EXTRACT: begin
                            if (sts.cursor_end) begin
                                cmd.res_sel = RES_END;
                            end else if (sts.code_empty) begin
                                cmd.res_load   = 1'b0;
                                cmd.cursor_inc = 1'b1;
                                state_next     = S_READ;
                            end else begin
                                cmd.cursor_inc = 1'b1;
                                cmd.res_sel    = RES_EXT;
                            end
                        end
                        default: cmd.res_sel = RES_DONE;
                    endcase
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Advance the state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            report_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            report_reg <= report_next;
        end
    end

endmodule

[rtl/core/hdde_dpath.sv]
// Datapath: tables, hash multiplier, probe registers, counters and result register.
// Depends on hdde_pkg and hdde_ram.
`timescale 1ns / 1ps

module hdde_dpath
    import hdde_pkg::*;
#(
    parameter int TABLE_BITS = 16,
    parameter int KEY_WIDTH  = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  cmd_t         cmd,
    output sts_t         sts,
    output logic         accepted,
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,
    output logic [2:0]   m_tuser
);

    localparam int TB = TABLE_BITS;
    localparam logic [TB-1:0] MULT_LO = HASH_MULT[TB-1:0];

    logic [2:0]           func_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [TB-1:0]        slot_reg;
    logic [15:0]          code_reg;
    logic [TB-1:0]        h_reg;
    logic [15:0]          p_reg;
    logic [TB-1:0]        d_reg;
    logic [TB-1:0]        d_next;
    logic [TB:0]          cursor_reg;
    logic [TB:0]          uniq_reg, uniq_next;
    logic [TB-1:0]        clr_reg;
    logic [15:0]          max_probes_reg;
    logic [63:0]          key_ext;
    logic [2*TB-1:0]      prod;
    logic [TB-1:0]        addr;
    logic [15:0]          code_wdata;
    logic [15:0]          code_sat;
    logic [KEY_WIDTH-1:0] key_rd;
    logic [15:0]          code_rd;
    logic                 m_valid_reg;
    logic [2:0]           r_stat_reg;
    logic [15:0]          r_slot_reg;
    logic [63:0]          r_key_reg;
    logic [15:0]          r_code_reg;
    logic [16:0]          r_uniq_reg;

    assign s_tready = cmd.in_ready;
    assign accepted = s_tvalid & cmd.in_ready;

    // Latch the input word
    always_ff @(posedge aclk) begin
        if (accepted) begin
            func_reg <= s_tuser;
            key_reg  <= s_tdata[KEY_WIDTH-1:0];
            slot_reg <= TB'(s_tdata[79:64]);
            code_reg <= s_tdata[95:80];
        end
    end

    // Home slot: only the low table bits of the product matter
    assign key_ext = 64'(key_reg);
    assign prod    = (2*TB)'(key_ext[TB-1:0]) * (2*TB)'(MULT_LO);
    assign d_next  = d_reg + TB'({p_reg, 1'b1});

    // Probe walk: offset grows by 2p+1 each step to give p*p
    always_ff @(posedge aclk) begin
        if (cmd.hash) begin
            h_reg <= prod[TB-1:0];
            p_reg <= '0;
            d_reg <= '0;
        end else if (cmd.step) begin
            h_reg <= h_reg + d_next;
            p_reg <= p_reg + 16'd1;
            d_reg <= d_next;
        end
    end

    // Table address and write data
    always_comb begin
        case (cmd.addr_sel)
            ADDR_PROBE:  addr = h_reg;
            ADDR_SLOT:   addr = slot_reg;
            ADDR_CURSOR: addr = cursor_reg[TB-1:0];
            default:     addr = clr_reg;
        endcase
    end

    assign code_sat = (code_reg == EMPTY_CODE) ? SAT_CODE : code_reg;

    always_comb begin
        case (cmd.code_wsel)
            CW_ZERO: code_wdata = '0;
            CW_CODE: code_wdata = code_sat;
            default: code_wdata = EMPTY_CODE;
        endcase
    end

    hdde_ram #(.WIDTH(KEY_WIDTH), .DEPTH(1 << TB)) u_key_ram (
        .aclk  (aclk),
        .we    (cmd.key_we),
        .addr  (addr),
        .wdata (key_reg),
        .rdata (key_rd)
    );

    hdde_ram #(.WIDTH(16), .DEPTH(1 << TB)) u_code_ram (
        .aclk  (aclk),
        .we    (cmd.code_we),
        .addr  (addr),
        .wdata (code_wdata),
        .rdata (code_rd)
    );

    // Counters and configuration
    assign uniq_next = cmd.clr_done ? '0 : (cmd.uniq_inc ? uniq_reg + 1'b1 : uniq_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg     <= '0;
            uniq_reg       <= '0;
            clr_reg        <= '0;
            max_probes_reg <= 16'hFFFF;
        end else begin
            uniq_reg <= uniq_next;
            if (cmd.clr_done) begin
                cursor_reg <= '0;
            end else if (cmd.cursor_inc) begin
                cursor_reg <= cursor_reg + 1'b1;
            end
            if (cmd.clr_step) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_wr_en) begin
                max_probes_reg <= cfg_wr_data;
            end
        end
    end

    // Result register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            r_uniq_reg <= 17'(uniq_next);
            r_stat_reg <= STAT_DONE;
            r_slot_reg <= '0;
            r_key_reg  <= '0;
            r_code_reg <= '0;
            case (cmd.res_sel)
                RES_NEW: begin
                    r_stat_reg <= STAT_NEW;
                    r_slot_reg <= 16'(h_reg);
                end
                RES_PRESENT: begin
                    r_stat_reg <= STAT_PRESENT;
                    r_slot_reg <= 16'(h_reg);
                    r_code_reg <= code_rd;
                end
                RES_FOUND: begin
                    r_slot_reg <= 16'(h_reg);
                    r_code_reg <= code_rd;
                end
                RES_NOTFOUND: r_stat_reg <= STAT_NOTFOUND;
                RES_LIMIT:    r_stat_reg <= STAT_LIMIT;
                RES_END:      r_stat_reg <= STAT_END;
                RES_WR_EMPTY: begin
                    r_stat_reg <= STAT_NOTFOUND;
                    r_slot_reg <= 16'(slot_reg);
                    r_code_reg <= EMPTY_CODE;
                end
                RES_WR_OK: begin
                    r_slot_reg <= 16'(slot_reg);
                    r_code_reg <= code_sat;
                end
                RES_EXT: begin
                    r_slot_reg <= 16'(cursor_reg[TB-1:0]);
                    r_key_reg  <= 64'(key_rd);
                    r_code_reg <= code_rd;
                end
                default: r_stat_reg <= STAT_DONE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = r_stat_reg;
    assign m_tdata  = {7'd0, r_uniq_reg, r_code_reg, r_key_reg, r_slot_reg};

    // Status back to the controller
    assign sts.func        = func_reg;
    assign sts.code_empty  = (code_rd == EMPTY_CODE);
    assign sts.key_match   = (key_rd == key_reg);
    assign sts.probe_limit = (p_reg >= max_probes_reg);
    assign sts.cursor_end  = cursor_reg[TB];
    assign sts.clr_last    = &clr_reg;
    assign sts.out_busy    = m_valid_reg & ~m_tready;

endmodule

[rtl/core/hash_dictionary_dedup_encoder.sv]
// Top level of the hash dictionary dedup encoder: controller plus datapath.
// Depends on hdde_pkg, hdde_ctrl, hdde_dpath and hdde_ram.
`timescale 1ns / 1ps

// Dictionary of up to 2^TABLE_BITS keys in an open-addressed table with quadratic
// probing (home slot = low bits of key * 0x9e3779b97f4a7c15, step p adds p*p).
// One operation per input word, selected by s_tuser, one result word each. Both
// tables sit in single-port RAMs, so every probe passes through a read state and a
// check state: an insert or lookup probes until a hit, an empty slot or the limit,
// a slot write reads and checks its one slot, an extract scans slots until the next
// full one or the end, and a clear sweeps the code table. After reset the same
// sweep runs before the first word is accepted; max_probes may be written meanwhile.
module hash_dictionary_dedup_encoder
    import hdde_pkg::*;
#(
    parameter int TABLE_BITS = 16,
    parameter int KEY_WIDTH  = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data,   // max_probes
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,       // key[63:0], slot[79:64], code[95:80]
    input  logic [2:0]   s_tuser,       // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,       // found_slot, found_key, found_code, unique_total
    output logic [2:0]   m_tuser        // status
);

    cmd_t cmd;
    sts_t sts;
    logic accepted;

    hdde_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .sts      (sts),
        .accepted (accepted),
        .cmd      (cmd)
    );

    hdde_dpath #(.TABLE_BITS(TABLE_BITS), .KEY_WIDTH(KEY_WIDTH)) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .accepted    (accepted),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

[tb/hash_dictionary_dedup_encoder_tb.sv]
// Self-checking testbench for hash_dictionary_dedup_encoder: stream driver,
// table predictor and result checker. Depends on hdde_pkg and the RTL only.
`timescale 1ns / 1ps

module hash_dictionary_dedup_encoder_tb;
    import hdde_pkg::*;

    localparam int TSIZE = 65536;
    localparam logic [15:0] LIMIT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] key;
        logic [15:0] slot;
        logic [15:0] code;
    } op_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] slot;
        logic [63:0] key;
        logic [15:0] code;
        logic [16:0] total;
    } dict_result_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [15:0]  cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [119:0] m_tdata;
    logic [2:0]   m_tuser;

    // Shadow copy of the dictionary
    logic [63:0]  tbl_keys [TSIZE];
    logic [15:0]  tbl_codes [TSIZE];
    int unsigned  scan_cursor;
    int unsigned  distinct_keys;
    logic [15:0]  probe_budget;

    op_word_t     pending_words[$];
    dict_result_t expected_results[$];
    logic [63:0]  inserted_keys[$];
    logic [15:0]  home_pool[$];
    int           fail_count;
    logic         word_taken;
    int unsigned  words_in;
    int unsigned  hold_left;
    logic         hold_done;

    hash_dictionary_dedup_encoder dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [15:0] home_of(input logic [63:0] k);
        logic [63:0] prod;
        prod = k * HASH_MULT;
        return prod[15:0];
    endfunction

    // Walk the probe sequence: 0 key found, 1 empty slot reached, 2 budget spent
    function automatic int probe_table(input logic [63:0] k, output logic [15:0] where);
        logic [15:0] h;
        int unsigned p;
        h = home_of(k);
        p = 0;
        where = '0;
        forever begin
            if (tbl_codes[h] == EMPTY_CODE) begin
                where = h;
                return 1;
            end
            if (tbl_keys[h] == k) begin
                where = h;
                return 0;
            end
            if (p >= probe_budget) return 2;
            p++;
            h = h + 16'(p * p);
        end
    endfunction

    // Apply one operation to the shadow table and return its result word
    function automatic dict_result_t predict_result(input op_word_t w);
        dict_result_t r;
        logic [15:0] where;
        logic [15:0] c;
        int rc;
        r = '0;
        r.status = STAT_DONE;
        case (w.func)
            FUNC_CLEAR: begin
                for (int i = 0; i < TSIZE; i++) tbl_codes[i] = EMPTY_CODE;
                distinct_keys = 0;
                scan_cursor = 0;
            end
            FUNC_INSERT: begin
                rc = probe_table(w.key, where);
                if (rc == 2) begin
                    r.status = STAT_LIMIT;
                end else begin
                    if (rc == 1) begin
                        tbl_keys[where] = w.key;
                        tbl_codes[where] = '0;
                        distinct_keys++;
                        r.status = STAT_NEW;
                    end else begin
                        r.status = STAT_PRESENT;
                    end
                    r.slot = where;
                    r.code = tbl_codes[where];
                end
            end
            FUNC_LOOKUP: begin
                rc = probe_table(w.key, where);
                if (rc == 2) begin
                    r.status = STAT_LIMIT;
                end else if (rc == 1) begin
                    r.status = STAT_NOTFOUND;
                end else begin
                    r.slot = where;
                    r.code = tbl_codes[where];
                end
            end
            FUNC_WRCODE: begin
                r.slot = w.slot;
                if (tbl_codes[w.slot] == EMPTY_CODE) begin
                    r.status = STAT_NOTFOUND;
                end else begin
                    c = (w.code == EMPTY_CODE) ? SAT_CODE : w.code;
                    tbl_codes[w.slot] = c;
                end
                r.code = tbl_codes[w.slot];
            end
            FUNC_EXTRACT: begin
                while (scan_cursor < TSIZE && tbl_codes[scan_cursor] == EMPTY_CODE)
                    scan_cursor++;
                if (scan_cursor >= TSIZE) begin
                    scan_cursor = TSIZE;
                    r.status = STAT_END;
                end else begin
                    r.slot = 16'(scan_cursor);
                    r.key = tbl_keys[scan_cursor];
                    r.code = tbl_codes[scan_cursor];
                    scan_cursor++;
                end
            end
            default: ;
        endcase
        r.total = 17'(distinct_keys);
        return r;
    endfunction

    // Track accepted words and config writes; predict at acceptance
    always @(posedge aclk) begin
        op_word_t w;
        if (!aresetn) begin
            word_taken <= 1'b0;
            words_in   <= 0;
        end else begin
            if (cfg_wr_en) probe_budget = cfg_wr_data;
            word_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                words_in <= words_in + 1;
                w.func = s_tuser;
                w.key  = s_tdata[63:0];
                w.slot = s_tdata[79:64];
                w.code = s_tdata[95:80];
                expected_results.push_back(predict_result(w));
            end
        end
    end

    // Compare each result word with the oldest expectation
    always @(posedge aclk) begin
        dict_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected");
                fail_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (m_tuser !== exp_r.status) begin
                    $error("status: expected %0d, actual %0d", exp_r.status, m_tuser);
                    fail_count++;
                end
                if (m_tdata[15:0] !== exp_r.slot) begin
                    $error("found_slot: expected %0h, actual %0h", exp_r.slot, m_tdata[15:0]);
                    fail_count++;
                end
                if (m_tdata[79:16] !== exp_r.key) begin
                    $error("found_key: expected %0h, actual %0h", exp_r.key, m_tdata[79:16]);
                    fail_count++;
                end
                if (m_tdata[95:80] !== exp_r.code) begin
                    $error("found_code: expected %0h, actual %0h", exp_r.code, m_tdata[95:80]);
                    fail_count++;
                end
                if (m_tdata[112:96] !== exp_r.total) begin
                    $error("unique_total: expected %0d, actual %0d", exp_r.total,
                           m_tdata[112:96]);
                    fail_count++;
                end
            end
        end
    end

    // Stretch of traffic with no idling on either side
    function automatic logic calm_window();
        return words_in >= 600 && words_in < 900;
    endfunction

    // Sender: advance to the next word after a handshake, idle at random
    always @(negedge aclk) begin
        op_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || word_taken) begin
            if (pending_words.size() > 0 &&
                (calm_window() || $urandom_range(99) >= 29)) begin
                w = pending_words.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= w.func;
                s_tdata  <= {w.code, w.slot, w.key};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, one long hold-off, one calm stretch
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && words_in >= 300) begin
            hold_done <= 1'b1;
            hold_left <= 500;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= calm_window() || $urandom_range(99) >= 29;
        end
    end

    task automatic push_word(input logic [2:0] f, input logic [63:0] k,
                             input logic [15:0] s, input logic [15:0] c);
        op_word_t w;
        w.func = f;
        w.key = k;
        w.slot = s;
        w.code = c;
        pending_words.push_back(w);
        if (f == FUNC_INSERT) inserted_keys.push_back(k);
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_limit(input logic [15:0] v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [63:0] random_key();
        logic [63:0] k;
        k = {$urandom, $urandom};
        if ($urandom_range(99) < 70)
            k[15:0] = home_pool[$urandom_range(home_pool.size() - 1)];
        return k;
    endfunction

    // Fill one random phase
    task automatic random_phase(input int n);
        int pick;
        logic [63:0] k;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                if (inserted_keys.size() > 0 && $urandom_range(3) == 0)
                    k = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
                else
                    k = random_key();
                push_word(FUNC_INSERT, k, 16'($urandom), 16'($urandom));
            end else if (pick < 65) begin
                if (inserted_keys.size() > 0 && $urandom_range(2) != 0)
                    k = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
                else
                    k = random_key();
                push_word(FUNC_LOOKUP, k, 16'($urandom), 16'($urandom));
            end else if (pick < 82) begin
                if (inserted_keys.size() > 0 && $urandom_range(3) != 0)
                    push_word(FUNC_WRCODE, 64'($urandom),
                              home_of(inserted_keys[$urandom_range(inserted_keys.size() - 1)]),
                              16'($urandom));
                else
                    push_word(FUNC_WRCODE, 64'($urandom), 16'($urandom), 16'($urandom));
            end else if (pick < 96) begin
                push_word(FUNC_EXTRACT, {$urandom, $urandom}, 16'($urandom), 16'($urandom));
            end else begin
                push_word(3'($urandom_range(7, 5)), {$urandom, $urandom}, 16'($urandom),
                          16'($urandom));
            end
        end
    endtask

    initial begin
        logic [63:0] k0;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = FUNC_CLEAR;
        m_tready    = 1'b0;
        fail_count  = 0;
        scan_cursor = 0;
        distinct_keys = 0;
        probe_budget = LIMIT_MAX;
        for (int i = 0; i < TSIZE; i++) begin
            tbl_keys[i]  = '0;
            tbl_codes[i] = EMPTY_CODE;
        end
        for (int i = 0; i < 40; i++) home_pool.push_back(16'($urandom));
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, every operation, special cases
        set_limit(LIMIT_MAX);
        push_word(FUNC_LOOKUP, 64'd0, '0, '0);
        push_word(FUNC_INSERT, 64'd0, '0, '0);
        push_word(FUNC_INSERT, '1, '1, '1);
        push_word(FUNC_INSERT, 64'd0, '0, '0);
        push_word(FUNC_LOOKUP, '1, '0, '0);
        push_word(FUNC_LOOKUP, 64'h0123_4567_89ab_cdef, '0, '0);
        push_word(FUNC_WRCODE, '0, home_of(64'd0), EMPTY_CODE);
        push_word(FUNC_WRCODE, '0, home_of('1), 16'd0);
        push_word(FUNC_WRCODE, '0, home_of('1) + 16'd7, 16'h1234);
        push_word(FUNC_LOOKUP, 64'd0, '0, '0);
        push_word(3'd5, '1, '1, '1);
        push_word(3'd6, '0, '0, '0);
        push_word(3'd7, '1, '0, '1);
        for (int i = 0; i < 4; i++) push_word(FUNC_EXTRACT, '0, '0, '0);
        push_word(FUNC_CLEAR, '1, '1, '1);
        push_word(FUNC_LOOKUP, '1, '0, '0);
        push_word(FUNC_INSERT, 64'hdead_beef_0000_0001, '0, '0);
        drain();

        // Tight budget: chains of keys sharing one home slot hit the limit
        set_limit(16'd1);
        k0 = 64'h5555_0000_0000_1234;
        for (int i = 0; i < 4; i++) push_word(FUNC_INSERT, k0 + (64'(i) << 32), '0, '0);
        push_word(FUNC_LOOKUP, k0 + (64'd9 << 32), '0, '0);
        push_word(FUNC_LOOKUP, k0 + (64'd1 << 32), '0, '0);
        drain();
        set_limit(16'd0);
        push_word(FUNC_LOOKUP, k0 + (64'd1 << 32), '0, '0);
        push_word(FUNC_INSERT, k0 + (64'd7 << 32), '0, '0);
        drain();

        // Random phases over several budgets
        set_limit(LIMIT_MAX);
        random_phase(450);
        drain();
        set_limit(16'd3);
        random_phase(350);
        drain();
        set_limit(16'd1);
        push_word(FUNC_CLEAR, '0, '0, '0);
        inserted_keys.delete();
        random_phase(350);
        drain();
        set_limit(16'd2);
        random_phase(250);
        drain();
        set_limit(LIMIT_MAX);
        random_phase(200);
        drain();
        repeat (50) @(posedge aclk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #40ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
